### rtl/core/nqp_pkg.sv
// ----------------------------------------------------------------------------
// nqp_pkg
// Shared types and constants for the normalized quaternion product pipeline.
// ----------------------------------------------------------------------------
package nqp_pkg;

    localparam int OUT_FRAC_BITS = 30;
    localparam int QW = OUT_FRAC_BITS + 1;
    localparam int RW = OUT_FRAC_BITS + 33;

    typedef struct packed {
        logic signed [31:0] a_w;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
    } nqp_in_t;

    typedef struct packed {
        logic signed [31:0] r_w;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic               degenerate;
    } nqp_out_t;

    // raw hamilton product
    typedef struct packed {
        logic [3:0][63:0] pv;
        logic             degen;
    } nqp_prod_t;

    // block scaled product in sign magnitude form
    typedef struct packed {
        logic [3:0]       neg;
        logic [3:0][30:0] mag;
        logic             degen;
    } nqp_norm_t;

    typedef struct packed {
        nqp_norm_t   base;
        logic [62:0] s;
    } nqp_sum_t;

    typedef struct packed {
        nqp_norm_t   base;
        logic [62:0] s;
        logic [63:0] res;
    } nqp_root_t;

    typedef struct packed {
        nqp_norm_t   base;
        logic [31:0] n;
    } nqp_len_t;

    typedef struct packed {
        nqp_norm_t            base;
        logic [31:0]          n;
        logic [3:0][RW-1:0]   rem;
        logic [3:0][QW-1:0]   q;
    } nqp_div_t;

endpackage

### rtl/core/normalized_quaternion_product.sv
// ----------------------------------------------------------------------------
// normalized_quaternion_product
// Unit-length hamilton product of two Q16.16 quaternions, Q2.30 result.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every cycle while the result
// channel is not stalled. The pipeline depth is set by the square root (one
// bit per stage, 32 stages) and the four restoring dividers (one quotient
// bit per stage). A stall on the result channel freezes the whole pipeline;
// s_ready follows m_ready whenever the output register holds a result. A
// zero-length input returns the identity with degenerate set.
module normalized_quaternion_product (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nqp_pkg::nqp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output nqp_pkg::nqp_out_t m_data
);

    logic en;
    logic prod_valid;
    logic sum_valid;
    logic len_valid;
    nqp_pkg::nqp_prod_t prod_data;
    nqp_pkg::nqp_sum_t  sum_data;
    nqp_pkg::nqp_len_t  len_data;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    nqp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (prod_valid),
        .out_data  (prod_data)
    );

    nqp_renorm u_renorm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (prod_valid),
        .in_data   (prod_data),
        .out_valid (sum_valid),
        .out_data  (sum_data)
    );

    nqp_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sum_valid),
        .in_data   (sum_data),
        .out_valid (len_valid),
        .out_data  (len_data)
    );

    nqp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (len_valid),
        .in_data   (len_data),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

endmodule

### rtl/core/nqp_front.sv
// ----------------------------------------------------------------------------
// nqp_front
// Input block scaling and the hamilton product, four register stages.
// ----------------------------------------------------------------------------
module nqp_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  nqp_pkg::nqp_in_t  in_data,
    output logic              out_valid,
    output nqp_pkg::nqp_prod_t out_data
);

    logic [7:0][31:0] mag_reg;
    logic [7:0]       neg_reg;
    logic [1:0][31:0] max_reg;
    logic             v1_reg;

    logic signed [7:0][31:0] sv_reg;
    logic                    dg2_reg;
    logic                    v2_reg;

    logic [3:0][3:0][63:0] pr_reg;
    logic                  dg3_reg;
    logic                  v3_reg;

    nqp_pkg::nqp_prod_t out_reg;
    logic               v4_reg;

    logic [7:0][31:0] raw;
    logic [7:0][31:0] mag_next;
    logic [7:0]       neg_next;
    logic [1:0][31:0] max_next;
    logic [1:0][31:0] mx_a;
    logic [1:0][31:0] mx_b;
    logic [1:0][4:0]  h;
    logic signed [7:0][31:0] sv_next;
    logic [3:0][3:0][63:0] pr_next;
    logic [3:0][63:0] pv_next;
    logic [32:0] rnd;
    logic [31:0] sc;

    assign raw = {in_data.a_w, in_data.a_x, in_data.a_y, in_data.a_z,
                  in_data.b_w, in_data.b_x, in_data.b_y, in_data.b_z};

    // element 7 is a_w, element 0 is b_z
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            neg_next[i] = raw[i][31];
            mag_next[i] = raw[i][31] ? (32'd0 - raw[i]) : raw[i];
        end
        for (int q = 0; q < 2; q++) begin
            mx_a[q] = (mag_next[4*q+3] > mag_next[4*q+2]) ? mag_next[4*q+3] : mag_next[4*q+2];
            mx_b[q] = (mag_next[4*q+1] > mag_next[4*q]) ? mag_next[4*q+1] : mag_next[4*q];
            max_next[q] = (mx_a[q] > mx_b[q]) ? mx_a[q] : mx_b[q];
        end
    end

    always_comb begin
        rnd = '0;
        sc  = '0;
        for (int q = 0; q < 2; q++) begin
            h[q] = '0;
            for (int b = 0; b < 32; b++) begin
                if (max_reg[q][b]) begin
                    h[q] = 5'(b);
                end
            end
        end
        for (int i = 0; i < 8; i++) begin
            if (h[i/4] > 5'd29) begin
                rnd = {1'b0, mag_reg[i]} + (33'd1 << (h[i/4] - 5'd30));
                sc  = 32'(rnd >> (h[i/4] - 5'd29));
            end else begin
                sc = mag_reg[i] << (5'd29 - h[i/4]);
            end
            sv_next[i] = neg_reg[i] ? (32'd0 - sc) : sc;
        end
    end

    // a index 0..3 = w,x,y,z maps to sv element 7-i, b to 3-j
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                pr_next[i][j] = 64'($signed(sv_reg[7-i]) * $signed(sv_reg[3-j]));
            end
        end
    end

    always_comb begin
        pv_next[3] = pr_reg[0][0] - pr_reg[1][1] - pr_reg[2][2] - pr_reg[3][3];
        pv_next[2] = pr_reg[0][1] + pr_reg[1][0] + pr_reg[2][3] - pr_reg[3][2];
        pv_next[1] = pr_reg[0][2] - pr_reg[1][3] + pr_reg[2][0] + pr_reg[3][1];
        pv_next[0] = pr_reg[0][3] + pr_reg[1][2] - pr_reg[2][1] + pr_reg[3][0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            max_reg       <= max_next;
            sv_reg        <= sv_next;
            dg2_reg       <= (max_reg[0] == 32'd0) || (max_reg[1] == 32'd0);
            pr_reg        <= pr_next;
            dg3_reg       <= dg2_reg;
            out_reg.pv    <= pv_next;
            out_reg.degen <= dg3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = out_reg;

endmodule

### rtl/core/nqp_renorm.sv
// ----------------------------------------------------------------------------
// nqp_renorm
// Block scaling of the product and its squared length, five register stages.
// ----------------------------------------------------------------------------
module nqp_renorm (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  nqp_pkg::nqp_prod_t in_data,
    output logic               out_valid,
    output nqp_pkg::nqp_sum_t  out_data
);

    logic [3:0][62:0] mag5_reg;
    logic [3:0]       neg5_reg;
    logic [62:0]      max5_reg;
    logic             dg5_reg;

    logic [3:0][62:0] mag6_reg;
    logic [3:0]       neg6_reg;
    logic [5:0]       h6_reg;
    logic             dg6_reg;

    nqp_pkg::nqp_norm_t n7_reg;
    nqp_pkg::nqp_norm_t n8_reg;
    logic [3:0][61:0]   sq8_reg;
    nqp_pkg::nqp_sum_t  out_reg;
    logic [4:0]         v_reg;

    logic [3:0][62:0] mag_next;
    logic [62:0] mx_a;
    logic [62:0] mx_b;
    logic [5:0]  h_next;
    logic [63:0] rnd;
    nqp_pkg::nqp_norm_t n7_next;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mag_next[i] = in_data.pv[i][63] ? 63'(64'd0 - in_data.pv[i]) : in_data.pv[i][62:0];
        end
        mx_a = (mag_next[3] > mag_next[2]) ? mag_next[3] : mag_next[2];
        mx_b = (mag_next[1] > mag_next[0]) ? mag_next[1] : mag_next[0];
    end

    always_comb begin
        h_next = '0;
        for (int b = 0; b < 63; b++) begin
            if (max5_reg[b]) begin
                h_next = 6'(b);
            end
        end
    end

    always_comb begin
        rnd = '0;
        n7_next.neg   = neg6_reg;
        n7_next.degen = dg6_reg;
        for (int i = 0; i < 4; i++) begin
            if (h6_reg > 6'd29) begin
                rnd = {1'b0, mag6_reg[i]} + (64'd1 << (h6_reg - 6'd30));
                n7_next.mag[i] = 31'(rnd >> (h6_reg - 6'd29));
            end else begin
                n7_next.mag[i] = 31'(mag6_reg[i] << (6'd29 - h6_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag5_reg <= mag_next;
            for (int i = 0; i < 4; i++) begin
                neg5_reg[i] <= in_data.pv[i][63];
            end
            max5_reg <= (mx_a > mx_b) ? mx_a : mx_b;
            dg5_reg  <= in_data.degen;

            mag6_reg <= mag5_reg;
            neg6_reg <= neg5_reg;
            h6_reg   <= h_next;
            dg6_reg  <= dg5_reg || (max5_reg == 63'd0);

            n7_reg <= n7_next;

            n8_reg <= n7_reg;
            for (int i = 0; i < 4; i++) begin
                sq8_reg[i] <= 62'(n7_reg.mag[i] * n7_reg.mag[i]);
            end

            out_reg.base <= n8_reg;
            out_reg.s    <= 63'(64'(sq8_reg[0]) + 64'(sq8_reg[1])
                                + 64'(sq8_reg[2]) + 64'(sq8_reg[3]));
        end
    end

    assign out_valid = v_reg[4];
    assign out_data  = out_reg;

endmodule

### rtl/core/nqp_sqrt.sv
// ----------------------------------------------------------------------------
// nqp_sqrt
// Integer square root of the squared length, one result bit per stage.
// ----------------------------------------------------------------------------
module nqp_sqrt (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  nqp_pkg::nqp_sum_t in_data,
    output logic              out_valid,
    output nqp_pkg::nqp_len_t out_data
);

    localparam int STAGES = 32;

    nqp_pkg::nqp_root_t pipe_reg [0:STAGES-1];
    nqp_pkg::nqp_root_t cur      [0:STAGES];
    logic [STAGES-1:0]  v_reg;

    always_comb begin
        cur[0].base = in_data.base;
        cur[0].s    = in_data.s;
        cur[0].res  = '0;
        for (int j = 1; j <= STAGES; j++) begin
            cur[j] = pipe_reg[j-1];
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
        nqp_pkg::nqp_root_t step;
        logic [63:0] trial;

        always_comb begin
            step  = cur[g];
            trial = cur[g].res + BIT;
            if ({1'b0, cur[g].s} >= trial) begin
                step.s   = 63'({1'b0, cur[g].s} - trial);
                step.res = (cur[g].res >> 1) + BIT;
            end else begin
                step.res = cur[g].res >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                pipe_reg[g] <= step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[STAGES-2:0], in_valid};
        end
    end

    assign out_valid     = v_reg[STAGES-1];
    assign out_data.base = cur[STAGES].base;
    assign out_data.n    = cur[STAGES].res[31:0];

endmodule

### rtl/core/nqp_div.sv
// ----------------------------------------------------------------------------
// nqp_div
// Rounded division of each component by the length, restoring, one quotient
// bit per stage, then saturation, sign and the identity for a degenerate input.
// ----------------------------------------------------------------------------
module nqp_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  nqp_pkg::nqp_len_t in_data,
    output logic              out_valid,
    output nqp_pkg::nqp_out_t out_data
);

    localparam int F  = nqp_pkg::OUT_FRAC_BITS;
    localparam int QW = nqp_pkg::QW;
    localparam int RW = nqp_pkg::RW;
    localparam int NS = QW + 2;

    nqp_pkg::nqp_div_t pipe_reg [0:QW];
    nqp_pkg::nqp_div_t setup;
    nqp_pkg::nqp_out_t out_reg;
    nqp_pkg::nqp_out_t out_next;
    logic [NS-1:0]     v_reg;
    logic [3:0][31:0]  r;

    always_comb begin
        setup.base = in_data.base;
        setup.n    = in_data.n;
        setup.q    = '0;
        for (int i = 0; i < 4; i++) begin
            setup.rem[i] = (RW'(in_data.base.mag[i]) << F) + RW'(in_data.n >> 1);
        end
    end

    for (genvar g = 0; g < QW; g++) begin : g_stage
        localparam int B = QW - 1 - g;
        nqp_pkg::nqp_div_t step;
        logic [RW-1:0] dvs;

        always_comb begin
            step = pipe_reg[g];
            dvs  = RW'(pipe_reg[g].n) << B;
            for (int i = 0; i < 4; i++) begin
                if (pipe_reg[g].rem[i] >= dvs) begin
                    step.rem[i]  = pipe_reg[g].rem[i] - dvs;
                    step.q[i][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                pipe_reg[g+1] <= step;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            r[i] = 32'(pipe_reg[QW].q[i]);
            if (r[i] > (32'd1 << F)) begin
                r[i] = 32'd1 << F;
            end
            r[i] = pipe_reg[QW].base.neg[i] ? (32'd0 - r[i]) : r[i];
        end
        if (pipe_reg[QW].base.degen || (pipe_reg[QW].n == 32'd0)) begin
            out_next.r_w        = 32'd1 << F;
            out_next.r_x        = '0;
            out_next.r_y        = '0;
            out_next.r_z        = '0;
            out_next.degenerate = 1'b1;
        end else begin
            out_next.r_w        = r[3];
            out_next.r_x        = r[2];
            out_next.r_y        = r[1];
            out_next.r_z        = r[0];
            out_next.degenerate = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= setup;
            out_reg     <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_data  = out_reg;

endmodule
